// ----- rtl/ssem_pkg.sv -----
package ssem_pkg;

    localparam int STORE_LINES = 32;
    localparam int LINE_W      = $clog2(STORE_LINES);
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int FUNC_LSB    = 13;
    localparam int UPC_W       = 3;

    localparam logic [LINE_W-1:0] HALT_LINE = LINE_W'(31);

    // tdata packing
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;

    typedef logic [UPC_W-1:0]  upc_t;
    typedef logic [LINE_W-1:0] line_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_JMP  = 3'd0,
        FN_JRP  = 3'd1,
        FN_LDN  = 3'd2,
        FN_STO  = 3'd3,
        FN_SUB  = 3'd4,
        FN_SUBX = 3'd5,
        FN_CMP  = 3'd6,
        FN_STP  = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ADDR_CI   = 2'd0,
        ADDR_LINE = 2'd1,
        ADDR_LOAD = 2'd2
    } addr_sel_t;

    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_ACCEPT = 3'd2,
        C_LOAD      = 3'd3,
        C_HALTED    = 3'd4
    } cond_t;

    // Micro-step numbers
    localparam upc_t U_IDLE  = 3'd0;
    localparam upc_t U_FETCH = 3'd1;
    localparam upc_t U_DEC   = 3'd2;
    localparam upc_t U_OPND  = 3'd3;
    localparam upc_t U_EXEC  = 3'd4;
    localparam upc_t U_EMIT  = 3'd5;
    localparam upc_t U_EMITZ = 3'd6;
    localparam upc_t U_LOAD  = 3'd7;

    typedef struct packed {
        logic      in_rdy;
        addr_sel_t addr_sel;
        logic      mem_we;     // store write of the load word
        logic      ir_ld;
        logic      exec;
        logic      emit;
        logic      emit_zero;
        cond_t     cond;
        upc_t      target;
    } ctl_t;

    typedef struct packed {
        logic accepted;
        logic is_load;
        logic halted;
        logic out_full;
    } stat_t;

    typedef struct packed {
        word_t          pi;
        logic [FUNC_W-1:0] fn;
        line_t          ci;
        logic signed [WORD_W-1:0] acc;
        logic           halted;
    } result_t;

    function automatic ctl_t ucode_rom(input upc_t upc);
        ctl_t w;
        w = '{in_rdy: 1'b0, addr_sel: ADDR_CI, mem_we: 1'b0, ir_ld: 1'b0, exec: 1'b0,
              emit: 1'b0, emit_zero: 1'b0, cond: C_NEVER, target: U_IDLE};
        case (upc)
            U_IDLE:
            begin
                w.in_rdy = 1'b1;
                w.cond   = C_NO_ACCEPT;
                w.target = U_IDLE;
            end
            U_FETCH:
            begin
                w.addr_sel = ADDR_CI;
                w.cond     = C_LOAD;
                w.target   = U_LOAD;
            end
            U_DEC:
            begin
                w.ir_ld  = 1'b1;
                w.cond   = C_HALTED;
                w.target = U_EMITZ;
            end
            U_OPND:
            begin
                w.addr_sel = ADDR_LINE;
            end
            U_EXEC:
            begin
                w.addr_sel = ADDR_LINE;
                w.exec     = 1'b1;
            end
            U_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
            U_EMITZ:
            begin
                w.emit      = 1'b1;
                w.emit_zero = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = U_IDLE;
            end
            U_LOAD:
            begin
                w.addr_sel = ADDR_LOAD;
                w.mem_we   = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = U_EMITZ;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/ssem_store.sv -----
module ssem_store
    import ssem_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  we,
    input  line_t addr,
    input  word_t wdata,
    output word_t rdata
);

    word_t                  mem [STORE_LINES];
    logic [STORE_LINES-1:0] valid_reg;
    word_t                  rdata_reg;

    // unwritten lines read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= valid_reg[addr] ? mem[addr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ssem_useq.sv -----
module ssem_useq
    import ssem_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    assign ctl = ucode_rom(upc_reg);

    always_comb
    begin
        case (ctl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !stat.accepted;
            C_LOAD:      take = stat.is_load;
            C_HALTED:    take = stat.halted;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (ctl.emit && stat.out_full)
        begin
            upc_next = upc_reg;           // hold until output stage frees
        end
        else if (take)
        begin
            upc_next = ctl.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- rtl/ssem_dpath.sv -----
module ssem_dpath
    import ssem_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctl_t    ctl,
    input  logic    in_load,
    input  logic    in_req_type,
    input  line_t   in_load_line,
    input  word_t   in_load_word,
    output logic    is_load,
    output logic    halted,
    output result_t result
);

    logic  req_type_reg;
    line_t load_line_reg;
    word_t load_word_reg;
    word_t ir_reg;
    line_t ci_reg;
    line_t ci_next;
    word_t acc_reg;
    word_t acc_next;
    logic  halt_reg;
    logic  halt_next;

    word_t s;
    func_t fn;
    line_t opnd_line;
    line_t ci_mid;
    line_t mem_addr;
    word_t mem_wdata;
    logic  mem_we;

    assign fn        = func_t'(ir_reg[FUNC_LSB +: FUNC_W]);
    assign opnd_line = ir_reg[LINE_W-1:0];

    always_comb
    begin
        case (ctl.addr_sel)
            ADDR_CI:   mem_addr = ci_reg;
            ADDR_LINE: mem_addr = opnd_line;
            ADDR_LOAD: mem_addr = load_line_reg;
            default:   mem_addr = ci_reg;
        endcase
    end

    assign mem_we    = ctl.mem_we || (ctl.exec && fn == FN_STO);
    assign mem_wdata = ctl.mem_we ? load_word_reg : acc_reg;

    ssem_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (s)
    );

    // execute: s holds the operand read in the previous step
    always_comb
    begin
        ci_mid   = ci_reg;
        acc_next = acc_reg;
        case (fn)
            FN_JMP:  ci_mid = s[LINE_W-1:0];
            FN_JRP:  ci_mid = ci_reg + s[LINE_W-1:0];
            FN_LDN:  acc_next = '0 - s;
            FN_STO:  ci_mid = ci_reg;
            FN_SUB,
            FN_SUBX: acc_next = acc_reg - s;
            FN_CMP:  ci_mid = acc_reg[WORD_W-1] ? ci_reg + 1'b1 : ci_reg;
            FN_STP:  ci_mid = ci_reg;
            default: ci_mid = ci_reg;
        endcase
        ci_next   = ci_mid + 1'b1;
        halt_next = (fn == FN_STP) || (ci_next == HALT_LINE);
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            req_type_reg  <= in_req_type;
            load_line_reg <= in_load_line;
            load_word_reg <= in_load_word;
        end
        if (ctl.ir_ld)
        begin
            ir_reg <= s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg   <= '0;
            acc_reg  <= '0;
            halt_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            ci_reg   <= ci_next;
            acc_reg  <= acc_next;
            halt_reg <= halt_next;
        end
    end

    assign is_load = !req_type_reg;
    assign halted  = halt_reg;

    assign result.pi     = ctl.emit_zero ? '0 : ir_reg;
    assign result.fn     = ctl.emit_zero ? '0 : ir_reg[FUNC_LSB +: FUNC_W];
    assign result.ci     = ci_reg;
    assign result.acc    = acc_reg;
    assign result.halted = halt_reg;

endmodule

// ----- rtl/ssem_processor_step_top.sv -----
// SSEM core, one word in and one word out per request.
// A load walks the fetch, load and emit steps; a step walks fetch, decode, operand, execute
// and emit, or fetch, decode and emit when halted. One request at a time, paced by the
// micro-program walking a single-port store with registered read; a full output stalls it.
// Reset (rst_n, async low) clears CI, accumulator, halt flag, store valid bits and
// the micro-step counter; the store reads as all zeros until written.
module ssem_processor_step_top
    import ssem_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request side
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // load_line[4:0], load_word[36:5], zero pad
    input  logic                   s_tuser,   // req_type: 0 load, 1 step
    // result side
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // present_instruction[31:0],
                                              // function_code[34:32], control_line[39:35],
                                              // accumulator_value[71:40], halted[72], pad
);

    ctl_t    ctl;
    stat_t   stat;
    result_t result;
    logic    accepted;
    logic    is_load;
    logic    halted;
    logic    out_full;
    logic    out_load;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign s_tready = ctl.in_rdy;
    assign accepted = s_tvalid && s_tready;

    // output word register parts the sequencer from the consumer
    assign out_full = m_tvalid_reg && !m_tready;
    assign out_load = ctl.emit && !out_full;

    assign stat = '{accepted: accepted, is_load: is_load, halted: halted,
                    out_full: out_full};

    ssem_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    ssem_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .in_load      (accepted),
        .in_req_type  (s_tuser),
        .in_load_line (s_tdata[LINE_W-1:0]),
        .in_load_word (s_tdata[LINE_W +: WORD_W]),
        .is_load      (is_load),
        .halted       (halted),
        .result       (result)
    );

    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {{(OUT_TDATA_W - $bits(result_t)){1'b0}},
                            result.halted, result.acc, result.ci, result.fn, result.pi};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // halt is sticky: only reset clears it
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n) !$fell(halted))
        else $error("halt flag dropped without reset");

    // a result word is never written over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result written while output stage full");

    // one request in flight: no accept straight after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> !s_tready)
        else $error("request accepted while previous one still in work");

endmodule

// ----- tb/ssem_step_monitor.sv -----
// Watches both stream channels, keeps a running copy of the machine and
// scores every result word against the oldest prediction.
module ssem_step_monitor
    import ssem_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // load_line[4:0], load_word[36:5], zero pad
    input  logic                   s_tuser,   // req_type: 0 load, 1 step
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // pi[31:0], fn[34:32], ci[39:35],
                                              // acc[71:40], halted[72], pad
    output int                     mismatches,
    output int                     outstanding,
    output logic                   halt_ahead, // a step from here would halt
    output line_t                  pred_ci
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FN_LSB  = WORD_W;
    localparam int CI_LSB  = FN_LSB + FUNC_W;
    localparam int ACC_LSB = CI_LSB + LINE_W;
    localparam int HLT_BIT = ACC_LSB + WORD_W;

    typedef struct packed {
        logic [STORE_LINES-1:0][WORD_W-1:0] mem;
        line_t                              ci;
        word_t                              acc;
        logic                               halt;
    } machine_t;

    machine_t mach;
    machine_t trial;
    result_t  due_results[$];
    result_t  want;
    result_t  got;
    result_t  fresh;
    int       fail_count;

    // One request applied to a machine; returns the new machine and the result word.
    function automatic machine_t next_machine(input machine_t m, input logic is_step,
                                              input line_t ln, input word_t w,
                                              output result_t r);
        word_t ir;
        word_t opnd;
        func_t fn;
        line_t tgt;
        logic  stop;
        ir   = '0;
        fn   = FN_JMP;
        stop = 1'b0;
        if (!is_step)
            m.mem[ln] = w;
        else if (!m.halt)
        begin
            ir   = m.mem[m.ci];
            fn   = func_t'(ir[FUNC_LSB +: FUNC_W]);
            tgt  = ir[LINE_W-1:0];
            opnd = m.mem[tgt];
            case (fn)
                FN_JMP:         m.ci = opnd[LINE_W-1:0];
                FN_JRP:         m.ci = m.ci + opnd[LINE_W-1:0];
                FN_LDN:         m.acc = -opnd;
                FN_STO:         m.mem[tgt] = m.acc;
                FN_SUB, FN_SUBX: m.acc = m.acc - opnd;
                FN_CMP:         if (m.acc[WORD_W-1]) m.ci = m.ci + 1'b1;
                default:        stop = 1'b1;
            endcase
            // counter wraps at 32; halt looks only at the final value
            m.ci = m.ci + 1'b1;
            if (stop || m.ci == HALT_LINE)
                m.halt = 1'b1;
        end
        r.pi     = ir;
        r.fn     = fn;
        r.ci     = m.ci;
        r.acc    = m.acc;
        r.halted = m.halt;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mach = '0;
            due_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.pi     = m_tdata[WORD_W-1:0];
                got.fn     = m_tdata[FN_LSB +: FUNC_W];
                got.ci     = m_tdata[CI_LSB +: LINE_W];
                got.acc    = m_tdata[ACC_LSB +: WORD_W];
                got.halted = m_tdata[HLT_BIT];
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word %h with nothing expected", $realtime, m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.pi !== want.pi || got.fn !== want.fn || got.ci !== want.ci ||
                        got.acc !== want.acc || got.halted !== want.halted)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp/got pi %h/%h fn %0d/%0d ci %0d/%0d acc %h/%h halted %b/%b",
                                     $realtime, want.pi, got.pi, want.fn, got.fn, want.ci, got.ci,
                                     want.acc, got.acc, want.halted, got.halted);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                mach = next_machine(mach, s_tuser, s_tdata[LINE_W-1:0],
                                    s_tdata[LINE_W +: WORD_W], fresh);
                due_results.push_back(fresh);
            end
        end
        trial       = next_machine(mach, 1'b1, '0, '0, fresh);
        halt_ahead  <= trial.halt && !mach.halt;
        pred_ci     <= mach.ci;
        outstanding <= due_results.size();
        mismatches  <= fail_count;
    end

endmodule

// ----- tb/testbench.sv -----
// Stimulus and verdict for the SSEM step core.
// The monitor beside the core does all prediction and scoring; this module only
// feeds request words, throttles both channels and decides pass or fail.
module testbench;
    import ssem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_LOAD       = 1'b0;
    localparam logic REQ_STEP       = 1'b1;
    localparam int   RESET_CYCLES   = 8;
    localparam int   WATCHDOG_LIMIT = 2000;   // quiet cycles, far above any legal stall
    localparam int   TAIL_CYCLES    = 24;     // settle time after the drain, before the verdict
    localparam int   ITEMS_TOTAL    = 1300;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // load_line[4:0], load_word[36:5], zero pad
    logic                   s_tuser;    // req_type: 0 load, 1 step
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // pi[31:0], fn[34:32], ci[39:35], acc[71:40], halted[72]

    int    mismatches;
    int    outstanding;
    logic  halt_ahead;
    line_t pred_ci;

    int send_idle_pct;
    int recv_idle_pct;
    int sent_items;
    int quiet_cycles;

    always #2 clk = ~clk;

    ssem_processor_step_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ssem_step_monitor i_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .halt_ahead  (halt_ahead),
        .pred_ci     (pred_ci)
    );

    // Result side back-pressure, redrawn every cycle.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic word_t instr(input func_t f, input line_t ln);
        word_t w;
        w = '0;
        w[FUNC_LSB +: FUNC_W] = f;
        w[LINE_W-1:0]         = ln;
        return w;
    endfunction

    // One request word. Entered and left at a falling edge; the sender may
    // hold off a random number of cycles first.
    task automatic send_word(input logic kind, input line_t ln, input word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, w, ln};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    // Step fields are don't-care to the core, so they carry noise.
    task automatic step_raw();
        send_word(REQ_STEP, line_t'($urandom), $urandom);
    endtask

    // Keeps the machine alive: while the next step would halt, the word at CI
    // is replaced by a fresh random one. Halting is saved for the very end.
    task automatic step_alive();
        while (halt_ahead)
            send_word(REQ_LOAD, pred_ci, $urandom);
        step_raw();
    endtask

    // Land CI on dest via a JMP whose operand sits on a line other than CI.
    task automatic jump_to(input line_t dest);
        line_t via;
        word_t w;
        via = pred_ci ^ line_t'(16);
        w   = $urandom;
        w[LINE_W-1:0] = dest - 1'b1;
        send_word(REQ_LOAD, via, w);
        send_word(REQ_LOAD, pred_ci, instr(FN_JMP, via));
        step_raw();
    endtask

    // Sender stands idle until every expected result word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int    send_pct[3];
        int    recv_pct[3];
        int    k;
        word_t w;
        send_pct = '{37, 74, 0};
        recv_pct = '{74, 37, 0};
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        sent_items    = 0;
        quiet_cycles  = 0;
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed program. Operands first, then one instruction per step.
        send_word(REQ_LOAD, 5'd20, 32'h8000_0000);
        send_word(REQ_LOAD, 5'd21, 32'hFFFF_FFFF);
        send_word(REQ_LOAD, 5'd31, 32'hFFFF_FFFF);
        send_word(REQ_LOAD, 5'd23, 32'd19);
        send_word(REQ_LOAD, 5'd24, 32'hFFFF_FFFD);
        step_alive();                                   // line 0 untouched: JMP to 0, CI 1
        send_word(REQ_LOAD, 5'd1, instr(FN_LDN, 5'd21));
        step_alive();                                   // A = 1
        send_word(REQ_LOAD, 5'd2, instr(FN_CMP, 5'd0));
        step_alive();                                   // A positive, no skip
        send_word(REQ_LOAD, 5'd3, instr(FN_SUB, 5'd31));
        step_alive();                                   // A = 2
        send_word(REQ_LOAD, 5'd4, instr(FN_SUBX, 5'd20));
        step_alive();                                   // A = 2 - min, negative
        send_word(REQ_LOAD, 5'd5, instr(FN_STO, 5'd5));
        step_alive();                                   // overwrites its own line
        send_word(REQ_LOAD, 5'd6, instr(FN_JRP, 5'd23));
        step_alive();                                   // relative jump to 26
        send_word(REQ_LOAD, 5'd26, instr(FN_JMP, 5'd24));
        step_alive();                                   // operand high bits masked, CI 30
        send_word(REQ_LOAD, 5'd30, instr(FN_CMP, 5'd0));
        step_alive();                                   // skip from 30 wraps past 31 to 0
        step_alive();

        // Random part in three throttling phases; the sender drains fully
        // between phases so that the core sees a completely idle pipe.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = send_pct[phase];
            recv_idle_pct = recv_pct[phase];
            while (sent_items < (ITEMS_TOTAL * (phase + 1)) / 3)
            begin
                case ($urandom_range(0, 9))
                    0:
                        send_word(REQ_LOAD, line_t'($urandom), $urandom);
                    1, 2:
                    begin
                        // short program at CI, then let it run
                        k = $urandom_range(2, 8);
                        for (int j = 0; j < k; j++)
                            send_word(REQ_LOAD, pred_ci + line_t'(j), $urandom);
                        repeat (k) step_alive();
                    end
                    3:
                    begin
                        case ($urandom_range(0, 4))
                            0:       w = 32'h8000_0000;
                            1:       w = 32'h7FFF_FFFF;
                            2:       w = '0;
                            3:       w = '1;
                            default: w = $urandom;
                        endcase
                        send_word(REQ_LOAD, line_t'($urandom), w);
                    end
                    default:
                        step_alive();
                endcase
            end
            drain();
        end

        // Halt once, by one of three routes, then poke the halted machine.
        case ($urandom_range(0, 2))
            0:
            begin
                send_word(REQ_LOAD, pred_ci, instr(FN_STP, line_t'($urandom)));
                step_raw();
            end
            1:
                jump_to(line_t'(31));
            default:
            begin
                jump_to(line_t'(30));
                send_word(REQ_LOAD, pred_ci, instr(FN_LDN, line_t'($urandom)));
                step_raw();                             // plain increment reaches 31
            end
        endcase
        repeat (3) step_raw();
        send_word(REQ_LOAD, line_t'($urandom), $urandom);
        send_word(REQ_LOAD, pred_ci, instr(FN_LDN, 5'd21));
        repeat (2) step_raw();

        s_tvalid <= 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ssem_pkg.sv
rtl/ssem_store.sv
rtl/ssem_useq.sv
rtl/ssem_dpath.sv
rtl/ssem_processor_step_top.sv
tb/ssem_step_monitor.sv
tb/testbench.sv
